FILE: rtl/wcss_pkg.sv
package wcss_pkg;

	// Expected header bytes, byte 0 in the low bits: magic then version 1
	localparam logic [63:0] HEADER_WORD = 64'h00000001_6d736100;

	localparam logic [7:0] LEB_PAYLOAD = 8'h7F;
	localparam logic [7:0] LEB_MORE    = 8'h80;
	localparam logic [5:0] LEB_GROUP_BITS = 6'd7;
	localparam logic [2:0] LEB_GROUP_MAX  = 3'd7;

	localparam logic [2:0] HEADER_LAST = 3'd7;
	localparam logic [3:0] HEADER_BYTES = 4'd8;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_CODE   = 3'd1,
		PH_SIZE   = 3'd2,
		PH_BODY   = 3'd3,
		PH_BAD    = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA       = 2'd0,
		KIND_BAD_HEADER = 2'd1,
		KIND_CLEAN_END  = 2'd2,
		KIND_TRUNC_END  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_SKIP    = 2'd0,
		OP_HOLD    = 2'd1,
		OP_DATA    = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TERM_NONE  = 2'd0,
		TERM_BAD   = 2'd1,
		TERM_CLEAN = 2'd2,
		TERM_TRUNC = 2'd3
	} term_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		logic       out_last;
	} out_t;

	// Work handed from the parser to the emitter
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] idx;
		op_t        op;
		term_t      term;
	} cmd_t;

endpackage

FILE: rtl/wcss_front.sv
module wcss_front #(
	parameter int SIZE_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  wcss_pkg::in_t  item,
	output logic           cmd_push,
	output wcss_pkg::cmd_t cmd,
	input  logic           cmd_full
);

	wcss_pkg::phase_t phase_q, phase_n;
	logic [2:0]            cnt_q, cnt_n;
	logic                  ok_q, ok_n, ok_next;
	logic [SIZE_WIDTH-1:0] accum_q, accum_n, accum_new;
	logic [2:0]            group_q, group_n;
	logic [SIZE_WIDTH-1:0] remain_q, remain_n;
	logic                  drop_q, drop_n;
	logic                  accept;
	logic [7:0]            b;
	logic [5:0]            shift;

	assign b      = item.in_byte;
	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	assign ok_next = ok_q && (b == wcss_pkg::HEADER_WORD[{cnt_q, 3'b000} +: 8]);
	assign shift   = 6'(group_q) * wcss_pkg::LEB_GROUP_BITS;
	// groups shifted past the size width fall off the top
	assign accum_new = accum_q | (SIZE_WIDTH'(b & wcss_pkg::LEB_PAYLOAD) << shift);

	// next state
	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		ok_n     = ok_q;
		accum_n  = accum_q;
		group_n  = group_q;
		remain_n = remain_q;
		drop_n   = drop_q;
		unique case (phase_q)
			wcss_pkg::PH_HEADER: begin
				if (cnt_q == wcss_pkg::HEADER_LAST) begin
					phase_n = ok_next ? wcss_pkg::PH_CODE : wcss_pkg::PH_BAD;
				end else if (item.in_last) begin
					phase_n = wcss_pkg::PH_BAD;
				end else begin
					cnt_n = cnt_q + 3'd1;
					ok_n  = ok_next;
				end
			end
			wcss_pkg::PH_CODE: begin
				drop_n  = (b == 8'd0);
				accum_n = '0;
				group_n = '0;
				phase_n = wcss_pkg::PH_SIZE;
			end
			wcss_pkg::PH_SIZE: begin
				accum_n = accum_new;
				if (group_q != wcss_pkg::LEB_GROUP_MAX) begin
					group_n = group_q + 3'd1;
				end
				if ((b & wcss_pkg::LEB_MORE) == 8'd0) begin
					remain_n = accum_new;
					phase_n  = (accum_new == '0) ? wcss_pkg::PH_CODE : wcss_pkg::PH_BODY;
				end
			end
			wcss_pkg::PH_BODY: begin
				remain_n = remain_q - SIZE_WIDTH'(1);
				if (remain_q == SIZE_WIDTH'(1)) begin
					phase_n = wcss_pkg::PH_CODE;
				end
			end
			wcss_pkg::PH_BAD: begin
				phase_n = wcss_pkg::PH_BAD;
			end
			default: begin
				phase_n = wcss_pkg::PH_HEADER;
			end
		endcase
	end

	// command to the emitter
	always_comb begin
		cmd.data = b;
		cmd.idx  = cnt_q;
		unique case (phase_q)
			wcss_pkg::PH_HEADER: begin
				if (cnt_q == wcss_pkg::HEADER_LAST && ok_next) begin
					cmd.op = wcss_pkg::OP_RELEASE;
				end else if (cnt_q == wcss_pkg::HEADER_LAST || item.in_last) begin
					cmd.op = wcss_pkg::OP_SKIP;
				end else begin
					cmd.op = wcss_pkg::OP_HOLD;
				end
			end
			wcss_pkg::PH_CODE: begin
				cmd.op = (b == 8'd0) ? wcss_pkg::OP_SKIP : wcss_pkg::OP_DATA;
			end
			wcss_pkg::PH_SIZE, wcss_pkg::PH_BODY: begin
				cmd.op = drop_q ? wcss_pkg::OP_SKIP : wcss_pkg::OP_DATA;
			end
			default: begin
				cmd.op = wcss_pkg::OP_SKIP;
			end
		endcase
		priority if (phase_q == wcss_pkg::PH_HEADER && phase_n == wcss_pkg::PH_BAD) begin
			cmd.term = wcss_pkg::TERM_BAD;
		end else if (item.in_last && phase_n == wcss_pkg::PH_CODE) begin
			cmd.term = wcss_pkg::TERM_CLEAN;
		end else if (item.in_last &&
		             (phase_n == wcss_pkg::PH_SIZE || phase_n == wcss_pkg::PH_BODY)) begin
			cmd.term = wcss_pkg::TERM_TRUNC;
		end else begin
			cmd.term = wcss_pkg::TERM_NONE;
		end
	end

	assign cmd_push = accept && (cmd.op != wcss_pkg::OP_SKIP || cmd.term != wcss_pkg::TERM_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wcss_pkg::PH_HEADER;
			cnt_q    <= '0;
			ok_q     <= 1'b1;
			accum_q  <= '0;
			group_q  <= '0;
			remain_q <= '0;
			drop_q   <= 1'b0;
		end else if (accept) begin
			if (item.in_last) begin
				// end of file: start over on the next byte
				phase_q  <= wcss_pkg::PH_HEADER;
				cnt_q    <= '0;
				ok_q     <= 1'b1;
				accum_q  <= '0;
				group_q  <= '0;
				remain_q <= '0;
				drop_q   <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				cnt_q    <= cnt_n;
				ok_q     <= ok_n;
				accum_q  <= accum_n;
				group_q  <= group_n;
				remain_q <= remain_n;
				drop_q   <= drop_n;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wcss_pkg::PH_BODY |-> remain_q != '0)
		else $error("body phase with nothing left to count");

endmodule

FILE: rtl/wcss_queue.sv
module wcss_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wcss_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output wcss_pkg::cmd_t rdata,
	output logic           empty
);

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);

	wcss_pkg::cmd_t entry_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("command queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("command queue underflow");

endmodule

FILE: rtl/wcss_back.sv
module wcss_back (
	input  logic           clk,
	input  logic           arst_n,
	input  wcss_pkg::cmd_t head,
	input  logic           head_empty,
	output logic           head_pop,
	output logic           empty,
	input  logic           pop,
	output wcss_pkg::out_t result
);

	logic [7:0]     hdr_q [8];
	logic [3:0]     idx_q;
	logic [3:0]     n_data, total;
	logic           has_term, gen_valid, step_last, load_ok, advance, is_hold;
	logic           res_valid_q;
	wcss_pkg::out_t res_q, gen;

	assign is_hold  = !head_empty && head.op == wcss_pkg::OP_HOLD;
	assign has_term = (head.term != wcss_pkg::TERM_NONE);

	always_comb begin
		unique case (head.op)
			wcss_pkg::OP_RELEASE: n_data = wcss_pkg::HEADER_BYTES;
			wcss_pkg::OP_DATA:    n_data = 4'd1;
			default:              n_data = 4'd0;
		endcase
	end

	assign total     = n_data + 4'(has_term);
	assign gen_valid = !head_empty && !is_hold;
	assign step_last = (idx_q == total - 4'd1);
	assign load_ok   = !res_valid_q || pop;
	assign advance   = gen_valid && load_ok;
	assign head_pop  = is_hold || (advance && step_last);

	always_comb begin
		gen.out_last = step_last;
		if (idx_q < n_data) begin
			gen.kind = wcss_pkg::KIND_DATA;
			// the eighth header byte is still in the command, not in the store
			if (head.op == wcss_pkg::OP_RELEASE && idx_q[2:0] != wcss_pkg::HEADER_LAST) begin
				gen.out_byte = hdr_q[idx_q[2:0]];
			end else begin
				gen.out_byte = head.data;
			end
		end else begin
			gen.out_byte = 8'd0;
			unique case (head.term)
				wcss_pkg::TERM_BAD:   gen.kind = wcss_pkg::KIND_BAD_HEADER;
				wcss_pkg::TERM_CLEAN: gen.kind = wcss_pkg::KIND_CLEAN_END;
				default:              gen.kind = wcss_pkg::KIND_TRUNC_END;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_hold) begin
			hdr_q[head.idx] <= head.data;
		end
		if (advance) begin
			res_q <= gen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (head_pop) begin
				idx_q <= '0;
			end else if (advance) begin
				idx_q <= idx_q + 4'd1;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign empty  = !res_valid_q;
	assign result = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) idx_q <= wcss_pkg::HEADER_BYTES)
		else $error("result step past the header release");
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q > 4'd1 |-> !head_empty && head.op == wcss_pkg::OP_RELEASE)
		else $error("multi-step emission outside a header release");

endmodule

FILE: rtl/wasm_custom_section_stripper.sv
// Passes a WebAssembly module through one byte per cycle unless full, with its custom
// sections removed. Header bytes are held until the eighth arrives; a good header
// then comes out as eight data items on consecutive cycles from the result register
// when popped, while a bad one gives a single bad-header item and the rest of that
// file is swallowed. After the header each byte gives at most one data item plus one
// end item on the final byte, so input and output both sustain one item per cycle
// unless held. The parser hands its work to the emitter through a two-entry command
// queue; full rises only when that queue is full, e.g. while the header release or a
// stalled consumer holds the emitter. No clearing pass is needed after reset.
module wasm_custom_section_stripper #(
	parameter int SIZE_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  wcss_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output wcss_pkg::out_t result
);

	logic           cmd_push, cmd_full, cmd_pop, cmd_empty;
	wcss_pkg::cmd_t cmd_in, cmd_head;

	wcss_front #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	wcss_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	wcss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (cmd_head),
		.head_empty (cmd_empty),
		.head_pop   (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

FILE: dv/tb_wasm_custom_section_stripper.sv
module tb_wasm_custom_section_stripper;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIZE_W = 32;
	localparam int LONG_HOLD = 48;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 72;
	localparam int MAX_REPORTS = 10;

	// Tracks the section parser and holds the items the stripper should produce
	class stripped_stream_sb;
		wcss_pkg::out_t expected_q[$];
		wcss_pkg::out_t fresh[$];
		wcss_pkg::phase_t phase;
		logic [7:0] hdr[8];
		logic [3:0] hdr_cnt;
		logic [31:0] size_acc;
		logic [2:0] size_grp;
		logic [31:0] body_left;
		logic dropping;
		int errors;
		int checked;
		int kind_seen[4];

		function new();
			clear_state();
			errors = 0;
			checked = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		function void clear_state();
			phase = wcss_pkg::PH_HEADER;
			hdr_cnt = '0;
			size_acc = '0;
			size_grp = '0;
			body_left = '0;
			dropping = 1'b0;
			foreach (hdr[i]) hdr[i] = 8'h00;
		endfunction

		function void emit(logic [7:0] b, wcss_pkg::kind_t k);
			wcss_pkg::out_t r;
			r.out_byte = b;
			r.kind = k;
			r.out_last = 1'b0;
			fresh.push_back(r);
		endfunction

		function void note_byte(wcss_pkg::in_t it);
			logic [63:0] wide;
			int shift;
			wcss_pkg::out_t r;
			fresh.delete();
			case (phase)
			wcss_pkg::PH_HEADER: begin
				hdr[hdr_cnt[2:0]] = it.in_byte;
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= wcss_pkg::HEADER_BYTES) begin
					if ({hdr[7], hdr[6], hdr[5], hdr[4], hdr[3], hdr[2], hdr[1], hdr[0]}
							== wcss_pkg::HEADER_WORD) begin
						foreach (hdr[i]) emit(hdr[i], wcss_pkg::KIND_DATA);
						phase = wcss_pkg::PH_CODE;
					end else begin
						emit(8'h00, wcss_pkg::KIND_BAD_HEADER);
						phase = wcss_pkg::PH_BAD;
					end
				end else if (it.in_last) begin
					emit(8'h00, wcss_pkg::KIND_BAD_HEADER);
					phase = wcss_pkg::PH_BAD;
				end
			end
			wcss_pkg::PH_CODE: begin
				dropping = (it.in_byte == 8'h00);
				if (!dropping) emit(it.in_byte, wcss_pkg::KIND_DATA);
				size_acc = '0;
				size_grp = '0;
				phase = wcss_pkg::PH_SIZE;
			end
			wcss_pkg::PH_SIZE: begin
				shift = int'(wcss_pkg::LEB_GROUP_BITS) * int'(size_grp);
				if (!dropping) emit(it.in_byte, wcss_pkg::KIND_DATA);
				// payload above the size width falls away
				if (shift < SIZE_W) begin
					wide = {56'd0, it.in_byte & wcss_pkg::LEB_PAYLOAD};
					wide = wide << shift;
					size_acc = size_acc | wide[31:0];
				end
				if (size_grp < wcss_pkg::LEB_GROUP_MAX) size_grp = size_grp + 3'd1;
				if ((it.in_byte & wcss_pkg::LEB_MORE) == 8'h00) begin
					body_left = size_acc;
					phase = (body_left == 0) ? wcss_pkg::PH_CODE : wcss_pkg::PH_BODY;
				end
			end
			wcss_pkg::PH_BODY: begin
				if (!dropping) emit(it.in_byte, wcss_pkg::KIND_DATA);
				body_left = body_left - 32'd1;
				if (body_left == 0) phase = wcss_pkg::PH_CODE;
			end
			default: begin
			end
			endcase
			if (it.in_last) begin
				if (phase == wcss_pkg::PH_CODE)
					emit(8'h00, wcss_pkg::KIND_CLEAN_END);
				else if (phase == wcss_pkg::PH_SIZE || phase == wcss_pkg::PH_BODY)
					emit(8'h00, wcss_pkg::KIND_TRUNC_END);
				clear_state();
			end
			if (fresh.size() > 0) begin
				r = fresh[fresh.size() - 1];
				r.out_last = 1'b1;
				fresh[fresh.size() - 1] = r;
			end
			foreach (fresh[i]) expected_q.push_back(fresh[i]);
		endfunction

		function void check_result(wcss_pkg::out_t got);
			wcss_pkg::out_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected item: byte %02h kind %0d last %0b",
						got.out_byte, got.kind, got.out_last);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			kind_seen[int'(want.kind)]++;
			if (got.out_byte !== want.out_byte || got.kind !== want.kind
					|| got.out_last !== want.out_last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch: want byte %02h kind %0d last %0b, %s%02h kind %0d last %0b",
						want.out_byte, want.kind, want.out_last, "got byte ",
						got.out_byte, got.kind, got.out_last);
			end
		endfunction

		function void close_out();
			if (expected_q.size() != 0) begin
				$display("%0d expected items never arrived", expected_q.size());
				errors += expected_q.size();
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	wcss_pkg::in_t item = '0;
	logic full;
	logic empty;
	wcss_pkg::out_t result;

	stripped_stream_sb sb = new();

	logic [7:0] file_q[$];
	bit quiet = 1'b0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int cycles = 0;
	int files_sent = 0;
	int bytes_sent = 0;
	int holds_done = 0;
	int full_stalls = 0;

	always #6 clk = ~clk;

	wasm_custom_section_stripper #(.SIZE_WIDTH(SIZE_W)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stuck after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end else if (arst_n) begin
			if (push && !full) sb.note_byte(item);
			if (push && full) full_stalls++;
			if (pop && !empty) sb.check_result(result);
		end
	end

	// consumer: random stalls, one long hold-off on request
	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		wcss_pkg::in_t nxt;
		nxt.in_byte = b;
		nxt.in_last = lst;
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		push <= 1'b1;
		item <= nxt;
		@(posedge clk);
		while (full) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_file();
		foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
		files_sent++;
	endtask

	task automatic put_header(input bit good);
		int k;
		for (k = 0; k < 8; k++) file_q.push_back(wcss_pkg::HEADER_WORD[8*k +: 8]);
		if (!good) begin
			k = $urandom_range(0, 7);
			file_q[k] = file_q[k] ^ (8'h01 << $urandom_range(0, 7));
		end
	endtask

	// form 0: plain LEB128, 1: padded with redundant groups, 2: overlong with dropped bits
	task automatic put_size(input int unsigned v, input int form);
		int unsigned rest;
		logic [7:0] b;
		int pad;
		rest = v;
		if (form == 2) begin
			b = {1'b0, rest[6:0]};
			file_q.push_back(b | wcss_pkg::LEB_MORE);
			repeat (3) file_q.push_back(wcss_pkg::LEB_MORE);
			b = 8'($urandom_range(0, 7));
			file_q.push_back(wcss_pkg::LEB_MORE | (b << 4));
			repeat ($urandom_range(0, 5)) begin
				b = 8'($urandom_range(0, 255));
				file_q.push_back(b | wcss_pkg::LEB_MORE);
			end
			b = 8'($urandom_range(0, 255));
			file_q.push_back(b & wcss_pkg::LEB_PAYLOAD);
		end else begin
			do begin
				b = {1'b0, rest[6:0]};
				rest = rest >> 7;
				if (rest != 0) b = b | wcss_pkg::LEB_MORE;
				file_q.push_back(b);
			end while (rest != 0);
			if (form == 1) begin
				pad = $urandom_range(1, 4);
				file_q[file_q.size() - 1] = file_q[file_q.size() - 1] | wcss_pkg::LEB_MORE;
				repeat (pad - 1) file_q.push_back(wcss_pkg::LEB_MORE);
				file_q.push_back(8'h00);
			end
		end
	endtask

	task automatic put_section(input logic [7:0] code, input int unsigned v, input int form);
		logic [7:0] b;
		file_q.push_back(code);
		put_size(v, form);
		repeat (v) begin
			b = 8'($urandom_range(0, 255));
			file_q.push_back(b);
		end
	endtask

	task automatic make_random_file();
		int n;
		int s;
		int v;
		int f;
		int cut;
		logic [7:0] code;
		logic [7:0] b;
		file_q.delete();
		if ($urandom_range(0, 15) == 0) begin
			// noise: almost certainly a bad or short header
			repeat ($urandom_range(1, 12)) begin
				b = 8'($urandom_range(0, 255));
				file_q.push_back(b);
			end
		end else begin
			put_header($urandom_range(0, 7) != 0);
			n = $urandom_range(0, 4);
			for (s = 0; s < n; s++) begin
				v = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
				f = $urandom_range(0, 4);
				code = 8'($urandom_range(1, 255));
				if ($urandom_range(0, 2) == 0) code = 8'h00;
				put_section(code, v, (f < 3) ? 0 : f - 2);
			end
			if ($urandom_range(0, 3) == 0) begin
				cut = $urandom_range(1, file_q.size());
				while (file_q.size() > cut) void'(file_q.pop_back());
			end
		end
	endtask

	initial begin
		int base;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header cut short
		file_q.delete();
		file_q.push_back(8'h00);
		file_q.push_back(8'h61);
		send_file();

		// wrong version, then a final byte that must be swallowed
		file_q.delete();
		put_header(1'b1);
		file_q[4] = 8'h02;
		file_q.push_back(8'hFF);
		send_file();

		// file ends right after a good header
		file_q.delete();
		put_header(1'b1);
		send_file();

		// empty custom section, one passed section, then cut inside a size
		file_q.delete();
		put_header(1'b1);
		file_q.push_back(8'h00);
		file_q.push_back(8'h00);
		file_q.push_back(8'hFF);
		file_q.push_back(8'h01);
		file_q.push_back(8'h80);
		file_q.push_back(8'h0B);
		file_q.push_back(8'h83);
		send_file();

		base = bytes_sent;
		hold_req = 1'b1;
		while (bytes_sent - base < RANDOM_BYTES) begin
			if (bytes_sent - base >= RANDOM_BYTES * 3 / 4) quiet = 1'b1;
			calm = ($urandom_range(0, 3) == 0);
			make_random_file();
			send_file();
		end
		push <= 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.close_out();

		$display("%0d files, %0d bytes in; %0d items checked",
			files_sent, bytes_sent, sb.checked);
		$display("  %0d data, %0d bad header, %0d clean end, %0d truncated end",
			sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
		$display("%0d cycles with input held off by full, %0d long consumer hold-offs, %0d errors",
			full_stalls, holds_done, sb.errors);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/wcss_pkg.sv
rtl/wcss_front.sv
rtl/wcss_queue.sv
rtl/wcss_back.sv
rtl/wasm_custom_section_stripper.sv
dv/tb_wasm_custom_section_stripper.sv
